### src/mlt_pkg.sv
// ----------------------------------------------------------------------------
// mlt_pkg
// Shared types and constants for the live MIDI transposer.
// ----------------------------------------------------------------------------
`default_nettype none

package mlt_pkg;

   localparam int          MAX_HELD_NOTES_DEF = 32;
   localparam logic [7:0]  NOTE_ON_TYPE       = 8'h90;
   localparam logic [7:0]  WINDOW_KEYS        = 8'd12;
   localparam logic [6:0]  TRIGGER_RESET      = 7'd24;
   localparam logic [6:0]  PITCH_MAX          = 7'd127;

   localparam int          REQ_DATA_W = 24;
   localparam int          RSP_DATA_W = 16;
   localparam int          CSR_ADDR_W = 3;

   // register index taken from address bit 2
   localparam logic        REG_ENABLE  = 1'b0;
   localparam logic        REG_TRIGGER = 1'b1;

   typedef struct packed {
      logic [3:0] shift;
      logic [3:0] port;
      logic [3:0] channel;
      logic [6:0] pitch;
   } held_entry_type;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_CLASSIFY = 7'b0000010,
      ST_SRCH_RD  = 7'b0000100,
      ST_SRCH_CMP = 7'b0001000,
      ST_SHIFT_RD = 7'b0010000,
      ST_SHIFT_WR = 7'b0100000,
      ST_DONE     = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

### src/midi_live_transposer.sv
// ----------------------------------------------------------------------------
// midi_live_transposer
// A transaction is accepted in IDLE, classified, and its result is registered from DONE;
// a note-off on a non-empty table first scans the held entries (SRCH_RD, SRCH_CMP)
// and on a match moves later entries up (SHIFT_RD, SHIFT_WR). A new transaction is
// accepted only once the last result has been issued; DONE waits while the output stalls.
// Synchronous reset empties the table, clears the transpose and enable.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_live_transposer
   import mlt_pkg::*;
#(
   parameter int MAX_HELD_NOTES = MAX_HELD_NOTES_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   // tdata: note_pitch[6:0], velocity[13:7], midi_channel[17:14], midi_port[21:18]
   input  wire [REQ_DATA_W-1:0]  req_tdata,
   // tuser: event_type[7:0]
   input  wire [7:0]             req_tuser,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   // tdata: out_pitch[6:0], was_control_key[7], table_overflow[8], current_shift[12:9]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   input  wire                   csr_psel,
   input  wire                   csr_penable,
   input  wire                   csr_pwrite,
   input  wire [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire [31:0]            csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int AW = (MAX_HELD_NOTES > 1) ? $clog2(MAX_HELD_NOTES) : 1;
   localparam int CW = $clog2(MAX_HELD_NOTES + 1);
   localparam logic [CW:0] DEPTH = (CW + 1)'(MAX_HELD_NOTES);

   state_type       state_ff, state_in;
   logic            enable_ff, enable_in;
   logic [6:0]      trigger_ff, trigger_in;
   logic [3:0]      shift_ff, shift_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   idx_ff, idx_in;

   logic [7:0]      type_ff;
   logic [6:0]      pitch_ff;
   logic [6:0]      vel_ff;
   logic [3:0]      chan_ff;
   logic [3:0]      port_ff;

   logic [6:0]      res_pitch_ff, res_pitch_in;
   logic            res_ctrl_ff, res_ctrl_in;
   logic            res_ovf_ff, res_ovf_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   held_entry_type  mem [MAX_HELD_NOTES];
   held_entry_type  rd_data_ff;
   held_entry_type  wr_data;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [AW-1:0]   rd_addr;

   logic            csr_write;
   logic            req_accept;
   logic [CW:0]     idx_p1;
   logic [CW:0]     idx_p2;
   logic [CW:0]     count_x;
   logic [7:0]      trig_diff;
   logic            in_window;
   logic [7:0]      sum_cur;
   logic [7:0]      sum_held;
   logic            entry_match;
   logic            out_free;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      unique case (csr_paddr[2])
         REG_ENABLE:  csr_prdata = {31'd0, enable_ff};
         REG_TRIGGER: csr_prdata = {25'd0, trigger_ff};
         default:     csr_prdata = 32'd0;
      endcase
   end

   assign idx_p1    = {1'b0, idx_ff} + (CW + 1)'(1);
   assign idx_p2    = {1'b0, idx_ff} + (CW + 1)'(2);
   assign count_x   = {1'b0, count_ff};
   assign trig_diff = {1'b0, pitch_ff} - {1'b0, trigger_ff};
   assign in_window = (pitch_ff >= trigger_ff) && (trig_diff < WINDOW_KEYS);
   assign sum_cur   = {1'b0, pitch_ff} + {4'd0, shift_ff};
   assign sum_held  = {1'b0, pitch_ff} + {4'd0, rd_data_ff.shift};
   assign entry_match = (rd_data_ff.pitch == pitch_ff) && (rd_data_ff.channel == chan_ff)
                        && (rd_data_ff.port == port_ff);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign rd_addr   = (state_ff == ST_SRCH_RD) ? idx_ff[AW-1:0] : idx_p1[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      enable_in    = enable_ff;
      trigger_in   = trigger_ff;
      shift_in     = shift_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      res_pitch_in = res_pitch_ff;
      res_ctrl_in  = res_ctrl_ff;
      res_ovf_in   = res_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = '{shift: shift_ff, port: port_ff, channel: chan_ff, pitch: pitch_ff};

      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_ENABLE: begin
               enable_in = csr_pwdata[0];
               if (!csr_pwdata[0]) begin
                  shift_in = 4'd0;
                  count_in = '0;
               end
            end
            REG_TRIGGER: trigger_in = csr_pwdata[6:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            res_pitch_in = pitch_ff;
            res_ctrl_in  = 1'b0;
            res_ovf_in   = 1'b0;
            idx_in       = '0;
            state_in     = ST_DONE;
            if (enable_ff && type_ff == NOTE_ON_TYPE) begin
               if (in_window) begin
                  shift_in    = trig_diff[3:0];
                  res_ctrl_in = 1'b1;
               end else if (vel_ff == 7'd0) begin
                  if (count_ff != '0) begin
                     state_in = ST_SRCH_RD;
                  end
               end else begin
                  if (count_x < DEPTH) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CW'(1);
                  end else begin
                     res_ovf_in = 1'b1;
                  end
                  res_pitch_in = sum_cur[7] ? PITCH_MAX : sum_cur[6:0];
               end
            end
         end
         ST_SRCH_RD: begin
            state_in = ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            if (entry_match) begin
               res_pitch_in = sum_held[7] ? PITCH_MAX : sum_held[6:0];
               if (idx_p1 < count_x) begin
                  state_in = ST_SHIFT_RD;
               end else begin
                  count_in = count_ff - CW'(1);
                  state_in = ST_DONE;
               end
            end else if (idx_p1 < count_x) begin
               idx_in   = idx_p1[CW-1:0];
               state_in = ST_SRCH_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SHIFT_RD: begin
            state_in = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data_ff;
            if (idx_p2 < count_x) begin
               idx_in   = idx_p1[CW-1:0];
               state_in = ST_SHIFT_RD;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'd0, shift_ff, res_ovf_ff, res_ctrl_ff, res_pitch_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= 1'b0;
         trigger_ff   <= TRIGGER_RESET;
         shift_ff     <= 4'd0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         trigger_ff   <= trigger_in;
         shift_ff     <= shift_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         type_ff  <= req_tuser;
         pitch_ff <= req_tdata[6:0];
         vel_ff   <= req_tdata[13:7];
         chan_ff  <= req_tdata[17:14];
         port_ff  <= req_tdata[21:18];
      end
      res_pitch_ff <= res_pitch_in;
      res_ctrl_ff  <= res_ctrl_in;
      res_ovf_ff   <= res_ovf_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // held-note table, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, count_ff} <= DEPTH)
      else $error("held count above table depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("ready right after accepted transaction");

   a_result_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[12:9] < 4'd12) && !(rsp_data_ff[7] && rsp_data_ff[8]))
      else $error("bad result shift or flags");

endmodule

`default_nettype wire
